/* sv/pcff_pkg.sv */
// Shared types, widths and constant functions for the power curve fog factor block.
// No dependencies.
package pcff_pkg;

  localparam int unsigned DistBits = 20;
  localparam int unsigned CfgBits  = (DistBits > 16) ? DistBits : 16;
  localparam int unsigned FracBits = 16;
  localparam int unsigned YBits    = 31;
  localparam int unsigned SBits    = 25;
  localparam int unsigned WBits    = 17;

  localparam logic [1:0] CFG_ENABLE = 2'd0;
  localparam logic [1:0] CFG_NEAR   = 2'd1;
  localparam logic [1:0] CFG_FAR    = 2'd2;
  localparam logic [1:0] CFG_POWER  = 2'd3;

  typedef enum logic [1:0] {
    MODE_ZERO = 2'd0,
    MODE_FULL = 2'd1,
    MODE_CALC = 2'd2
  } mode_e;

  typedef struct packed {
    logic  vld;
    logic  usable;
    mode_e mode;
  } side_t;

  function automatic logic [63:0] isqrt64(input logic [63:0] v);
    logic [63:0] r;
    logic [63:0] b;
    logic [63:0] x;
    r = '0;
    b = 64'd1 << 62;
    x = v;
    for (int k = 0; k < 32; k++) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // c(i) ~ 2^(-2^-i) in Q.30
  function automatic logic [YBits-1:0] exp_coef(input int i);
    logic [63:0] c;
    c = isqrt64(64'd1 << 59);
    for (int k = 1; k < 16; k++) begin
      if (k < i) c = isqrt64(c << 30);
    end
    return c[YBits-1:0];
  endfunction

endpackage

/* sv/pcff_if.sv */
// Valid/ready channel interfaces for distance words in and fog words out.
// Depends on pcff_pkg.
interface pcff_in_if;
  logic                         valid;
  logic                         ready;
  logic [pcff_pkg::DistBits-1:0] eye_distance;
  modport source (output valid, eye_distance, input ready);
  modport sink   (input valid, eye_distance, output ready);
endinterface

interface pcff_out_if;
  logic                      valid;
  logic                      ready;
  logic [pcff_pkg::WBits-1:0] fog_weight;
  logic                      curve_usable;
  modport source (output valid, fog_weight, curve_usable, input ready);
  modport sink   (input valid, fog_weight, curve_usable, output ready);
endinterface

/* sv/power_curve_fog_factor.sv */
// Top level of the power curve fog factor: config registers, entry stage, cell chains, output.
// Depends on pcff_pkg, pcff_if, pcff_div_cell, pcff_log_cell, pcff_exp_cell.
//
//   channel | dir | word
//   in_i    | in  | eye_distance
//   out_o   | out | fog_weight, curve_usable
//   cfg     | in  | cfg_we_i, cfg_idx_i, cfg_data_i
//
// One word per cycle while the chain is not held; stages: entry, 16 divide cells, normalize,
// 16 log cells, two scale stages, 16 exp cells, output register.
// Whole chain advances together; it holds when out_o is valid and not ready.
// Reset clears config to enable 0, near 0, far 0, power 1.0, and empties the chain.
module power_curve_fog_factor (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [1:0]                    cfg_idx_i,
  input  logic [pcff_pkg::CfgBits-1:0]  cfg_data_i,
  pcff_in_if.sink                       in_i,
  pcff_out_if.source                    out_o
);
  import pcff_pkg::*;

  localparam int unsigned NCell = FracBits;

  logic                en;
  logic                enable_q;
  logic [DistBits-1:0] near_q, far_q, den;
  logic [15:0]         power_q;
  logic                usable;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= 1'b0;
      near_q   <= '0;
      far_q    <= '0;
      power_q  <= 16'd4096;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_ENABLE: enable_q <= cfg_data_i[0];
        CFG_NEAR:   near_q   <= cfg_data_i[DistBits-1:0];
        CFG_FAR:    far_q    <= cfg_data_i[DistBits-1:0];
        CFG_POWER:  power_q  <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  assign den    = far_q - near_q;
  assign usable = enable_q && (far_q >= near_q) && (power_q != '0);

  // output register gates the whole chain
  side_t          out_side_q;
  logic [WBits-1:0] out_w_q;
  assign en          = !out_side_q.vld || out_o.ready;
  assign in_i.ready  = en;

  // entry stage
  side_t               ent_side_q, ent_side_d;
  logic [DistBits-1:0] ent_rem_q;
  logic [DistBits-1:0] d;

  always_comb begin
    d              = in_i.eye_distance;
    ent_side_d.vld    = in_i.valid;
    ent_side_d.usable = usable;
    if (!usable) ent_side_d.mode = MODE_ZERO;
    else if (far_q == near_q) ent_side_d.mode = (d > near_q) ? MODE_FULL : MODE_ZERO;
    else if (d <= near_q) ent_side_d.mode = MODE_ZERO;
    else if (d >= far_q) ent_side_d.mode = MODE_FULL;
    else ent_side_d.mode = MODE_CALC;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_side_q <= '0;
    end else if (en) begin
      ent_side_q <= ent_side_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) ent_rem_q <= d - near_q;
  end

  // divide chain
  side_t               dv_side [NCell+1];
  logic [DistBits-1:0] dv_rem  [NCell+1];
  logic [FracBits-1:0] dv_quot [NCell+1];

  assign dv_side[0] = ent_side_q;
  assign dv_rem[0]  = ent_rem_q;
  assign dv_quot[0] = '0;

  for (genvar g = 0; g < NCell; g++) begin : g_div
    pcff_div_cell u_cell (
      .clk_i, .rst_ni, .en_i(en),
      .side_i(dv_side[g]), .den_i(den), .rem_i(dv_rem[g]), .quot_i(dv_quot[g]),
      .side_o(dv_side[g+1]), .rem_o(dv_rem[g+1]), .quot_o(dv_quot[g+1])
    );
  end

  // normalize
  logic [FracBits-1:0] t;
  logic [3:0]          e_d, nrm_e_q;
  logic [YBits-1:0]    nrm_y_q;
  side_t               nrm_side_q, nrm_side_d;

  always_comb begin
    t   = dv_quot[NCell];
    e_d = '0;
    for (int k = 0; k < FracBits; k++) begin
      if (t[k]) e_d = 4'(k);
    end
    nrm_side_d = dv_side[NCell];
    if (t == '0) nrm_side_d.mode = (dv_side[NCell].mode == MODE_CALC) ? MODE_ZERO
                                                                      : dv_side[NCell].mode;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nrm_side_q <= '0;
    end else if (en) begin
      nrm_side_q <= nrm_side_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      nrm_e_q <= e_d;
      nrm_y_q <= YBits'({15'd0, t} << (5'd30 - {1'b0, e_d}));
    end
  end

  // log chain
  side_t               lg_side [NCell+1];
  logic [YBits-1:0]    lg_y    [NCell+1];
  logic [FracBits-1:0] lg_l    [NCell+1];
  logic [3:0]          lg_e    [NCell+1];

  assign lg_side[0] = nrm_side_q;
  assign lg_y[0]    = nrm_y_q;
  assign lg_l[0]    = '0;
  assign lg_e[0]    = nrm_e_q;

  for (genvar g = 0; g < NCell; g++) begin : g_log
    pcff_log_cell u_cell (
      .clk_i, .rst_ni, .en_i(en),
      .side_i(lg_side[g]), .y_i(lg_y[g]), .l_i(lg_l[g]), .e_i(lg_e[g]),
      .side_o(lg_side[g+1]), .y_o(lg_y[g+1]), .l_o(lg_l[g+1]), .e_o(lg_e[g+1])
    );
  end

  // negated log, then scale by power
  side_t            ng_side_q, sc_side_q, sc_side_d;
  logic [20:0]      ng_n_q;
  logic [SBits-1:0] sc_s_q, sc_s_d;
  logic [36:0]      prod;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ng_side_q <= '0;
      sc_side_q <= '0;
    end else if (en) begin
      ng_side_q <= lg_side[NCell];
      sc_side_q <= sc_side_d;
    end
  end

  always_comb begin
    prod      = {16'd0, ng_n_q} * {21'd0, power_q} + 37'd2048;
    sc_s_d    = prod[12 +: SBits];
    sc_side_d = ng_side_q;
    if (ng_side_q.mode == MODE_CALC && sc_s_d[SBits-1:16] >= 9'd17) begin
      sc_side_d.mode = MODE_ZERO;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ng_n_q <= {5'd16 - {1'b0, lg_e[NCell]}, 16'd0} - {5'd0, lg_l[NCell]};
      sc_s_q <= sc_s_d;
    end
  end

  // exp chain
  side_t            ex_side [NCell+1];
  logic [YBits-1:0] ex_r    [NCell+1];
  logic [SBits-1:0] ex_s    [NCell+1];

  assign ex_side[0] = sc_side_q;
  assign ex_r[0]    = YBits'(32'd1 << 30);
  assign ex_s[0]    = sc_s_q;

  for (genvar g = 0; g < NCell; g++) begin : g_exp
    localparam logic [YBits-1:0] Coef = exp_coef(g + 1);
    pcff_exp_cell u_cell (
      .clk_i, .rst_ni, .en_i(en),
      .side_i(ex_side[g]), .coef_i(Coef), .sel_i(ex_s[g][FracBits-1-g]),
      .r_i(ex_r[g]), .s_i(ex_s[g]),
      .side_o(ex_side[g+1]), .r_o(ex_r[g+1]), .s_o(ex_s[g+1])
    );
  end

  // final shift, round and select
  logic [YBits-1:0] r_sh;
  logic [YBits-1:0] r_rnd;
  logic [WBits-1:0] w_d;

  always_comb begin
    r_sh  = ex_r[NCell] >> ex_s[NCell][20:16];
    r_rnd = r_sh + YBits'(8192);
    case (ex_side[NCell].mode)
      MODE_FULL: w_d = WBits'(65536);
      MODE_CALC: w_d = r_rnd[14 +: WBits];
      default:   w_d = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_side_q <= '0;
    end else if (en) begin
      out_side_q <= ex_side[NCell];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) out_w_q <= w_d;
  end

  assign out_o.valid        = out_side_q.vld;
  assign out_o.fog_weight   = out_w_q;
  assign out_o.curve_usable = out_side_q.usable;
endmodule

/* sv/pcff_div_cell.sv */
// One restoring-division cell: one quotient bit per stage.
// Depends on pcff_pkg.
module pcff_div_cell (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  pcff_pkg::side_t               side_i,
  input  logic [pcff_pkg::DistBits-1:0] den_i,
  input  logic [pcff_pkg::DistBits-1:0] rem_i,
  input  logic [pcff_pkg::FracBits-1:0] quot_i,
  output pcff_pkg::side_t               side_o,
  output logic [pcff_pkg::DistBits-1:0] rem_o,
  output logic [pcff_pkg::FracBits-1:0] quot_o
);
  import pcff_pkg::*;

  side_t               side_q;
  logic [DistBits-1:0] rem_q, rem_d;
  logic [FracBits-1:0] quot_q, quot_d;
  logic [DistBits:0]   rem2;
  logic                ge;

  always_comb begin
    rem2   = {rem_i, 1'b0};
    ge     = rem2 >= {1'b0, den_i};
    rem_d  = ge ? DistBits'(rem2 - {1'b0, den_i}) : rem2[DistBits-1:0];
    quot_d = {quot_i[FracBits-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_q <= '0;
    end else if (en_i) begin
      side_q <= side_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q  <= rem_d;
      quot_q <= quot_d;
    end
  end

  assign side_o = side_q;
  assign rem_o  = rem_q;
  assign quot_o = quot_q;
endmodule

/* sv/pcff_log_cell.sv */
// One log2 cell: square the mantissa and take one fraction bit of the log.
// Depends on pcff_pkg.
module pcff_log_cell (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  pcff_pkg::side_t               side_i,
  input  logic [pcff_pkg::YBits-1:0]    y_i,
  input  logic [pcff_pkg::FracBits-1:0] l_i,
  input  logic [3:0]                    e_i,
  output pcff_pkg::side_t               side_o,
  output logic [pcff_pkg::YBits-1:0]    y_o,
  output logic [pcff_pkg::FracBits-1:0] l_o,
  output logic [3:0]                    e_o
);
  import pcff_pkg::*;

  side_t               side_q;
  logic [YBits-1:0]    y_q, y_d;
  logic [FracBits-1:0] l_q, l_d;
  logic [3:0]          e_q;
  logic [2*YBits-1:0]  sq;
  logic [YBits:0]      y2;

  always_comb begin
    sq  = {{YBits{1'b0}}, y_i} * {{YBits{1'b0}}, y_i};
    y2  = sq[30 +: YBits+1];
    y_d = y2[YBits] ? y2[YBits:1] : y2[YBits-1:0];
    l_d = {l_i[FracBits-2:0], y2[YBits]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_q <= '0;
    end else if (en_i) begin
      side_q <= side_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      y_q <= y_d;
      l_q <= l_d;
      e_q <= e_i;
    end
  end

  assign side_o = side_q;
  assign y_o    = y_q;
  assign l_o    = l_q;
  assign e_o    = e_q;
endmodule

/* sv/pcff_exp_cell.sv */
// One exp2 cell: conditional multiply by a root-of-one-half coefficient.
// Depends on pcff_pkg.
module pcff_exp_cell (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  pcff_pkg::side_t            side_i,
  input  logic [pcff_pkg::YBits-1:0] coef_i,
  input  logic                       sel_i,
  input  logic [pcff_pkg::YBits-1:0] r_i,
  input  logic [pcff_pkg::SBits-1:0] s_i,
  output pcff_pkg::side_t            side_o,
  output logic [pcff_pkg::YBits-1:0] r_o,
  output logic [pcff_pkg::SBits-1:0] s_o
);
  import pcff_pkg::*;

  side_t              side_q;
  logic [YBits-1:0]   r_q, r_d;
  logic [SBits-1:0]   s_q;
  logic [2*YBits-1:0] prod;

  always_comb begin
    prod = {{YBits{1'b0}}, r_i} * {{YBits{1'b0}}, coef_i};
    r_d  = sel_i ? prod[30 +: YBits] : r_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_q <= '0;
    end else if (en_i) begin
      side_q <= side_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_q <= r_d;
      s_q <= s_i;
    end
  end

  assign side_o = side_q;
  assign r_o    = r_q;
  assign s_o    = s_q;
endmodule

/* verif/tb_pcff_if.sv */
// Testbench copy note: the channel interfaces live in sv/pcff_if.sv; this file holds
// the testbench-side expected fog word type only. Depends on pcff_pkg.
`timescale 1ns / 100ps
package tb_pcff_pkg;
  import pcff_pkg::*;

  typedef struct {
    logic [WBits-1:0] fog_weight;
    logic             curve_usable;
  } fog_word_t;
endpackage

/* verif/tb_top.sv */
// Self-checking testbench for power_curve_fog_factor: a queue-fed driver, a stalling
// monitor and a fixed-point fog predictor. Depends on pcff_pkg, pcff_if, tb_pcff_pkg.
`timescale 1ns / 100ps
module tb_top;
  import pcff_pkg::*;
  import tb_pcff_pkg::*;

  localparam int Latency = 53;
  localparam int WatchLimit = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [1:0] cfg_idx_i = CFG_ENABLE;
  logic [CfgBits-1:0] cfg_data_i = '0;

  pcff_in_if in_ch ();
  pcff_out_if out_ch ();

  power_curve_fog_factor dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_i(in_ch.sink), .out_o(out_ch.source)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor copy of the registers
  logic        fog_en;
  logic [19:0] fog_nr, fog_fr;
  logic [15:0] fog_pw;

  logic [19:0] dist_q[$];
  fog_word_t   fog_expect_q[$];
  int errors = 0;
  int idle_cycles = 0;

  function automatic logic [63:0] sq_root(input logic [63:0] v);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [16:0] curve_weight(input logic [63:0] t, input logic [63:0] p);
    int e;
    logic [63:0] y, lf, n, s, ip, r, c;
    e = 0;
    lf = 0;
    for (int i = 0; i < 16; i++) if (t[i]) e = i;
    y = t << (30 - e);
    for (int i = 0; i < 16; i++) begin
      y = (y * y) >> 30;
      lf = lf << 1;
      if (y >= (64'd1 << 31)) begin
        y = y >> 1;
        lf = lf | 64'd1;
      end
    end
    n = (64'(16 - e) << 16) - lf;
    s = (n * p + 64'd2048) >> 12;
    ip = s >> 16;
    if (ip >= 17) return 17'd0;
    r = 64'd1 << 30;
    c = sq_root(64'd1 << 59);
    for (int i = 1; i <= 16; i++) begin
      if (s[16 - i]) r = (r * c) >> 30;
      c = sq_root(c << 30);
    end
    r = r >> ip;
    r = (r + 64'd8192) >> 14;
    return (r > 65536) ? 17'd65536 : r[16:0];
  endfunction

  function automatic fog_word_t predict_fog(input logic [19:0] d);
    fog_word_t w;
    logic [63:0] t;
    w.curve_usable = fog_en && fog_fr >= fog_nr && fog_pw != 0;
    w.fog_weight = 0;
    if (w.curve_usable) begin
      if (fog_fr == fog_nr) w.fog_weight = (d > fog_nr) ? 17'd65536 : 17'd0;
      else if (d <= fog_nr) w.fog_weight = 0;
      else if (d >= fog_fr) w.fog_weight = 17'd65536;
      else begin
        t = (64'(d - fog_nr) << 16) / 64'(fog_fr - fog_nr);
        w.fog_weight = (t == 0) ? 17'd0 : curve_weight(t, 64'(fog_pw));
      end
    end
    return w;
  endfunction

  // driver: bursts and gaps
  int burst_left = 0, gap_left = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
      in_ch.eye_distance <= '0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        fog_expect_q.push_back(predict_fog(in_ch.eye_distance));
        void'(dist_q.pop_front());
      end
      if (in_ch.valid && !in_ch.ready) begin
      end else if (dist_q.size() != 0 && gap_left == 0) begin
        in_ch.valid <= 1'b1;
        in_ch.eye_distance <= dist_q[0];
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 40);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left--;
        end
      end else begin
        in_ch.valid <= 1'b0;
        if (gap_left > 0) gap_left--;
      end
    end
  end

  // monitor with its own stall pattern
  logic [7:0] stall_lfsr = 8'h5a;
  int stall_mode = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        idle_cycles <= 0;
        if (fog_expect_q.size() == 0) begin
          $display("%0t unexpected word: weight %0d usable %0d", $time,
                   out_ch.fog_weight, out_ch.curve_usable);
          errors++;
        end else begin
          fog_word_t x;
          x = fog_expect_q.pop_front();
          if (x.fog_weight !== out_ch.fog_weight || x.curve_usable !== out_ch.curve_usable) begin
            $display("%0t exp weight %0d usable %0d, got weight %0d usable %0d", $time,
                     x.fog_weight, x.curve_usable, out_ch.fog_weight, out_ch.curve_usable);
            errors++;
          end
        end
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      stall_lfsr <= {stall_lfsr[6:0], stall_lfsr[7] ^ stall_lfsr[5] ^ stall_lfsr[4] ^ stall_lfsr[3]};
      if ($urandom_range(0, 199) == 0) stall_mode = $urandom_range(0, 2);
      case (stall_mode)
        0: out_ch.ready <= 1'b1;
        1: out_ch.ready <= stall_lfsr[0] | stall_lfsr[2];
        default: out_ch.ready <= stall_lfsr[1] & stall_lfsr[3];
      endcase
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && idle_cycles >= WatchLimit) begin
      $display("power_curve_fog_factor: mismatch");
      $finish;
    end
  end

  task automatic drain();
    while (dist_q.size() != 0 || in_ch.valid || fog_expect_q.size() != 0) @(posedge clk_i);
    repeat (Latency + 4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [CfgBits-1:0] v);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_ENABLE: fog_en = v[0];
      CFG_NEAR: fog_nr = v[19:0];
      CFG_FAR: fog_fr = v[19:0];
      default: fog_pw = v[15:0];
    endcase
  endtask

  task automatic set_curve(input logic en, input logic [19:0] nr, input logic [19:0] fr,
                           input logic [15:0] pw);
    write_reg(CFG_ENABLE, CfgBits'(en));
    write_reg(CFG_NEAR, CfgBits'(nr));
    write_reg(CFG_FAR, CfgBits'(fr));
    write_reg(CFG_POWER, CfgBits'(pw));
  endtask

  function automatic logic [19:0] pick_dist();
    int unsigned span;
    case ($urandom_range(0, 7))
      0: return 20'($urandom);
      1: return 20'(32'(fog_nr) + $urandom_range(0, 2) - 1);
      2: return 20'(32'(fog_fr) + $urandom_range(0, 2) - 1);
      default: begin
        if (fog_fr > fog_nr) begin
          span = 32'(fog_fr - fog_nr);
          return 20'(32'(fog_nr) + $urandom_range(0, span));
        end
        return 20'($urandom);
      end
    endcase
  endfunction

  initial begin
    logic [19:0] a, b;
    logic [15:0] pw;
    fog_en = 0; fog_nr = 0; fog_fr = 0; fog_pw = 16'd4096;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    // reset config: unusable
    dist_q.push_back(20'd0);
    dist_q.push_back(20'hFFFFF);
    drain();
    set_curve(1'b1, 20'd100, 20'd1100, 16'd4096);
    dist_q.push_back(20'd0);
    dist_q.push_back(20'd100);
    dist_q.push_back(20'd101);
    dist_q.push_back(20'd600);
    dist_q.push_back(20'd1099);
    dist_q.push_back(20'd1100);
    dist_q.push_back(20'hFFFFF);
    dist_q.push_back(20'h55555);
    dist_q.push_back(20'hAAAAA);
    drain();
    set_curve(1'b1, 20'd500, 20'd500, 16'hFFFF);
    dist_q.push_back(20'd499); dist_q.push_back(20'd500); dist_q.push_back(20'd501);
    drain();
    set_curve(1'b1, 20'd0, 20'hFFFFF, 16'd1);
    dist_q.push_back(20'd1); dist_q.push_back(20'd16); dist_q.push_back(20'hFFFFE);
    drain();
    set_curve(1'b1, 20'd10, 20'd5, 16'd4096);
    dist_q.push_back(20'd7);
    drain();
    set_curve(1'b1, 20'd0, 20'd1000, 16'd0);
    dist_q.push_back(20'd500);
    drain();
    for (int ph = 0; ph < 18; ph++) begin
      a = 20'($urandom); b = 20'($urandom);
      if ($urandom_range(0, 3) != 0 && a > b) begin a ^= b; b ^= a; a ^= b; end
      if ($urandom_range(0, 1)) b = 20'(32'(a) + $urandom_range(1, 3000));
      case ($urandom_range(0, 3))
        0: pw = 16'($urandom);
        1: pw = 16'($urandom_range(1, 16384));
        2: pw = (ph % 2) ? 16'hFFFF : 16'd1;
        default: pw = 16'd4096;
      endcase
      set_curve($urandom_range(0, 7) != 0, a, b, pw);
      for (int k = 0; k < 100; k++) dist_q.push_back(pick_dist());
      if (ph == 9) drain();
      else while (dist_q.size() != 0) @(posedge clk_i);
      drain();
    end
    if (errors == 0) begin
      $display("power_curve_fog_factor: match");
    end else begin
      $display("power_curve_fog_factor: mismatch");
    end
    $finish;
  end
endmodule
